// ===== design/msb_first_bit_field_packer_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef MSB_FIRST_BIT_FIELD_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_PACKER_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define PKR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define PKR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pkr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pkr_pkg;

   localparam int MESSAGE_BYTES = 12;
   localparam int MSG_BITS      = 8 * MESSAGE_BYTES;
   localparam int NIBBLES       = 2 * MESSAGE_BYTES;
   localparam int NIB_W         = $clog2(NIBBLES);
   localparam int CUR_W         = $clog2(MSG_BITS + 1);

   localparam int OP_W      = 2;
   localparam int VALUE_W   = 64;
   localparam int WIDTH_W   = 7;
   localparam int HEX_W     = 7;
   localparam int STATUS_W  = 2;
   localparam int CMP_W     = (CUR_W > WIDTH_W) ? CUR_W : WIDTH_W;
   localparam int WIDE_W    = (MSG_BITS > VALUE_W) ? MSG_BITS : VALUE_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [HEX_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [HEX_W-1:0] CHAR_NINE = 7'h39;
   localparam logic [HEX_W-1:0] CHAR_A    = 7'h41;
   localparam logic [HEX_W-1:0] CHAR_F    = 7'h46;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FIT   = 2'd1,
      ST_SPACE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      K_CLEAR,
      K_APPEND,
      K_REJECT,
      K_READ,
      K_NONE
   } kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } bk_state_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALUE_W-1:0]   value;
      logic [WIDTH_W-1:0]   width;
   } cmd_type;

   function automatic logic [HEX_W-1:0] hex_of(input logic [3:0] nib);
      logic [HEX_W-1:0] n;
      n = HEX_W'(nib);
      if (nib < 4'd10) begin
         return CHAR_ZERO + n;
      end
      return CHAR_A + n - HEX_W'(10);
   endfunction

endpackage

`default_nettype wire

// ===== design/pkr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pkr_front import pkr_pkg::*; (
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [VALUE_W-1:0]   req_value,
   input  wire logic [WIDTH_W-1:0]   req_field_width,
   input  wire logic                 q_full,
   output logic                      push,
   output cmd_type                   push_cmd
);

   logic fits;

   // shifts of 64 or more give zero, so wide fields always fit
   assign fits = ((req_value >> req_field_width) == '0);

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_cmd.value = req_value;
      push_cmd.width = req_field_width;
      unique case (op_type'(req_operation))
         OP_CLEAR:  push_cmd.kind = K_CLEAR;
         OP_APPEND: push_cmd.kind = fits ? K_APPEND : K_REJECT;
         OP_READ:   push_cmd.kind = K_READ;
         OP_NONE:   push_cmd.kind = K_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/pkr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pkr_queue import pkr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire cmd_type  push_cmd,
   input  wire logic     pop,
   output logic          q_full,
   output logic          q_valid,
   output cmd_type       q_cmd
);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;

   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== design/pkr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pkr_back import pkr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire cmd_type              q_cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [HEX_W-1:0]          rsp_hex_char,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic                      rsp_last
);

   bk_state_type            state_ff, state_in;
   logic [MSG_BITS-1:0]     msg_ff, msg_in;
   logic [CUR_W-1:0]        cur_ff, cur_in;
   logic [NIB_W-1:0]        idx_ff, idx_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HEX_W-1:0]        hex_ff;
   status_type              status_ff;
   logic                    last_ff;

   logic                    out_free;
   logic                    emit;
   logic [HEX_W-1:0]        res_hex;
   status_type              res_status;
   logic                    res_last;

   logic [CUR_W-1:0]        room;
   logic                    no_room;
   logic [CUR_W-1:0]        shift;
   logic [WIDE_W-1:0]       wide_value;
   logic [MSG_BITS-1:0]     field;
   logic [MSG_BITS-1:0]     mask;
   logic [MSG_BITS-1:0]     merged;
   logic [3:0]              nibble;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // insert position: field MSB lands at the cursor, counted from the buffer MSB
   assign room       = CUR_W'(MSG_BITS) - cur_ff;
   assign no_room    = CMP_W'(q_cmd.width) > CMP_W'(room);
   assign shift      = room - CUR_W'(q_cmd.width);
   assign wide_value = WIDE_W'(q_cmd.value);
   assign field      = wide_value[MSG_BITS-1:0];
   assign mask       = ~({MSG_BITS{1'b1}} << q_cmd.width);
   assign merged     = (msg_ff & ~(mask << shift)) | ((field & mask) << shift);

   assign nibble = msg_ff[{idx_ff, 2'b00} +: 4];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free && (q_cmd.kind == K_READ)) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (out_free && (idx_ff == '0)) begin
               state_in = BK_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      pop        = 1'b0;
      emit       = 1'b0;
      res_hex    = '0;
      res_status = ST_OK;
      res_last   = 1'b1;
      msg_in     = msg_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               pop = 1'b1;
               unique case (q_cmd.kind)
                  K_CLEAR: begin
                     emit   = 1'b1;
                     msg_in = '0;
                     cur_in = '0;
                  end
                  K_APPEND: begin
                     emit = 1'b1;
                     if (no_room) begin
                        res_status = ST_SPACE;
                     end else begin
                        msg_in = merged;
                        cur_in = cur_ff + CUR_W'(q_cmd.width);
                     end
                  end
                  K_REJECT: begin
                     emit       = 1'b1;
                     res_status = ST_FIT;
                  end
                  K_READ: begin
                     // highest nibble of byte 0 goes out first
                     idx_in = NIB_W'(NIBBLES - 1);
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            if (out_free) begin
               emit     = 1'b1;
               res_hex  = hex_of(nibble);
               res_last = (idx_ff == '0);
               idx_in   = idx_ff - 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         msg_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         msg_ff       <= msg_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (emit) begin
         hex_ff    <= res_hex;
         status_ff <= res_status;
         last_ff   <= res_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hex_char = hex_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

// ===== design/msb_first_bit_field_packer.sv =====
// A clear or append result goes through the command queue and the output register;
// the first read-out character also goes through the read entry step between them.
// Throughput while the output is not stalled: one clear or append per cycle;
// a read-out holds the execute side for an entry step, then one hex char per cycle.
// A 2-entry command queue decouples request acceptance from execution.
// Reset (synchronous, active high) clears the buffer, cursor, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_field_packer import pkr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [VALUE_W-1:0]   req_value,
   input  wire logic [WIDTH_W-1:0]   req_field_width,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [HEX_W-1:0]          rsp_hex_char,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic                      rsp_last
);

   logic     q_full;
   logic     q_valid;
   logic     push;
   logic     pop;
   cmd_type  push_cmd;
   cmd_type  q_cmd;

   pkr_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_field_width (req_field_width),
      .q_full          (q_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   pkr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   pkr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hex_char (rsp_hex_char),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// ===== design/pkr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "msb_first_bit_field_packer_defines.svh"

module pkr_checker import pkr_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [HEX_W-1:0]     rsp_hex_char,
   input wire logic [STATUS_W-1:0]  rsp_status,
   input wire logic                 rsp_last
);

   // a stalled response keeps its payload
   `PKR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hex_char) && $stable(rsp_status) && $stable(rsp_last), "response changed while stalled")

   // only read-out yields non-final results, and those carry a hex digit
   `PKR_ASSERT(a_readout_char, clock, reset, rsp_valid && !rsp_last |-> rsp_status == ST_OK && ((rsp_hex_char >= CHAR_ZERO && rsp_hex_char <= CHAR_NINE) || (rsp_hex_char >= CHAR_A && rsp_hex_char <= CHAR_F)), "bad read-out character")

   // a rejected append is a single result with no character
   `PKR_ASSERT(a_reject_shape, clock, reset, rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_hex_char == '0 && (rsp_status == ST_FIT || rsp_status == ST_SPACE), "bad reject response")

   `PKR_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response valid right after reset")

endmodule

bind msb_first_bit_field_packer pkr_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_hex_char (rsp_hex_char),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last)
);

`default_nettype wire
